FILE: hw/rtl/sdss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdss_pkg;

    // Default sizes of the index space and of the list layout.
    localparam int SDSS_INDEX_SPACE = 4096;
    localparam int SDSS_LIST_DEPTH  = 64;

    // Width of the generation mark kept beside every stored word.
    localparam int EPOCH_W = 6;

    localparam int VALUE_W = 64;
    localparam int INDEX_W = 12;
    localparam int PTS_W   = 13;
    localparam int RATIO_W = 17;
    localparam int THR_W   = 7;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [VALUE_W-1:0] NAN_WORD = 64'h7FF8_0000_0000_0000;

    // Actions.
    localparam logic [1:0] ACT_PREPARE = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_LIST_MISS    = 3'd1;
    localparam logic [2:0] ST_NOT_PREPARED = 3'd2;
    localparam logic [2:0] ST_LIST_FULL    = 3'd3;
    localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;

    // Layouts.
    localparam logic [1:0] LAYOUT_UNSET = 2'd0;
    localparam logic [1:0] LAYOUT_LIST  = 2'd1;
    localparam logic [1:0] LAYOUT_DENSE = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_POINTS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXISTING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

    localparam logic [PTS_W-1:0]   POINTS_RST    = 13'd4096;
    localparam logic [PTS_W-1:0]   EXISTING_RST  = 13'd0;
    localparam logic [RATIO_W-1:0] RATIO_RST     = 17'd13107;
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 7'd64;

    typedef struct packed {
        logic [1:0]         action;
        logic [INDEX_W-1:0] flat_index;
        logic [VALUE_W-1:0] value_in;
    } req_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic [2:0]         status;
        logic [1:0]         layout;
    } rsp_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sdss_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sdss_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 70
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sparse_dense_surplus_store.sv
// An accepted transaction reads the memory and waits in S_LOOK; its result is registered
// once the output register is free. No new transaction is taken before the last one
// finishes, as the single memory is read and then written. A prepare that wraps the
// generation mark (every 2**EPOCH_W - 1 prepares) is followed by a clearing pass over
// all INDEX_SPACE entries while no transaction is accepted. Reset is asynchronous and
// active low; after it the same clearing pass runs before the first transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none

module sparse_dense_surplus_store
    import sdss_pkg::*;
#(
    parameter int INDEX_SPACE = SDSS_INDEX_SPACE,
    parameter int LIST_DEPTH  = SDSS_LIST_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire req_item_t            req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output rsp_item_t                 rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // All stored words live in one memory addressed by the flat index. Each word
    // carries a generation mark; a word counts as written only when its mark equals
    // the current generation, so a prepare empties the store by stepping the
    // generation instead of touching every entry.
    //
    // The list layout keeps its words in the same memory. Because list keys are
    // always below the dense size, the index itself locates the entry, and a
    // current mark means the key is in the list. A count of list entries limits
    // the list to LIST_DEPTH keys, which gives the same hit, miss and full answers
    // as a searched key list.

    localparam int ADDR_W = $clog2(INDEX_SPACE);
    localparam int MEM_W  = EPOCH_W + VALUE_W;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int LIM_W  = ($clog2(INDEX_SPACE + 1) > PTS_W) ?
                            $clog2(INDEX_SPACE + 1) : PTS_W;
    localparam int PROD_W = RATIO_W + PTS_W;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_LOOK
    } state_t;

    // Configuration registers.
    logic [PTS_W-1:0]   points_reg;
    logic [PTS_W-1:0]   existing_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [THR_W-1:0]   threshold_reg;

    // Control state and registered outputs.
    state_t             state_reg, state_next;
    logic [1:0]         layout_reg, layout_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [ADDR_W-1:0]  sweep_reg, sweep_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg, rsp_next;

    // Transaction held while its memory read completes.
    req_item_t          item_reg;

    // Memory ports.
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [MEM_W-1:0]   mem_rd_data;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [MEM_W-1:0]   mem_wr_data;

    // Derived values used while a transaction finishes.
    logic               accept;
    logic               finish;
    logic               hit;
    logic [LIM_W-1:0]   points_ext;
    logic [LIM_W-1:0]   dense_limit;
    logic               in_range;
    logic [PROD_W-1:0]  occupancy_lhs;
    logic [PROD_W-1:0]  occupancy_rhs;
    logic               pick_list;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A result can be loaded when the output register is empty or being emptied.
    assign finish = (state_reg == S_LOOK) && (!rsp_valid_reg || !rsp_stall);

    assign mem_rd_en   = accept;
    assign mem_rd_addr = ADDR_W'(req.flat_index);

    assign hit = (mem_rd_data[MEM_W-1:VALUE_W] == epoch_reg);

    // The dense size is the point count, capped at the memory depth.
    assign points_ext  = LIM_W'(points_reg);
    assign dense_limit = (points_ext < LIM_W'(INDEX_SPACE)) ? points_ext : LIM_W'(INDEX_SPACE);
    assign in_range    = LIM_W'(item_reg.flat_index) < dense_limit;

    // The occupancy test existing/points < ratio/2**16, cross-multiplied.
    assign occupancy_lhs = PROD_W'({existing_reg, 16'h0000});
    assign occupancy_rhs = PROD_W'(ratio_reg) * PROD_W'(points_reg);
    assign pick_list     = (occupancy_lhs < occupancy_rhs) &&
                           (existing_reg < PTS_W'(threshold_reg));

    sdss_ram #(
        .DEPTH (INDEX_SPACE),
        .WIDTH (MEM_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg    <= POINTS_RST;
            existing_reg  <= EXISTING_RST;
            ratio_reg     <= RATIO_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINTS:    points_reg    <= cfg_data[PTS_W-1:0];
                REG_EXISTING:  existing_reg  <= cfg_data[PTS_W-1:0];
                REG_RATIO:     ratio_reg     <= cfg_data[RATIO_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    // Next-state logic. The memory is read when a transaction is accepted and
    // written back, if at all, when it finishes in S_LOOK. Only one transaction is in
    // flight, so a read never overlaps a pending write to the same entry.
    always_comb
    begin
        state_next     = state_reg;
        layout_next    = layout_reg;
        count_next     = count_reg;
        epoch_next     = epoch_reg;
        sweep_next     = sweep_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = ADDR_W'(item_reg.flat_index);
        mem_wr_data    = {epoch_reg, item_reg.value_in};

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_SWEEP:
            begin
                // Every mark goes back to zero, a generation never in use.
                mem_wr_en   = 1'b1;
                mem_wr_addr = sweep_reg;
                mem_wr_data = '0;
                sweep_next  = sweep_reg + ADDR_W'(1);
                if (sweep_reg == ADDR_W'(INDEX_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                if (finish)
                begin
                    state_next         = S_IDLE;
                    rsp_valid_next     = 1'b1;
                    rsp_next.value_out = '0;
                    rsp_next.status    = ST_OK;

                    unique case (item_reg.action)
                        ACT_PREPARE:
                        begin
                            layout_next = pick_list ? LAYOUT_LIST : LAYOUT_DENSE;
                            count_next  = '0;
                            if (epoch_reg == '1)
                            begin
                                // Generations are used up: clear all marks first.
                                epoch_next = EPOCH_W'(1);
                                sweep_next = '0;
                                state_next = S_SWEEP;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + EPOCH_W'(1);
                            end
                        end

                        ACT_WRITE, ACT_READ:
                        begin
                            if (layout_reg == LAYOUT_UNSET)
                            begin
                                rsp_next.status = ST_NOT_PREPARED;
                            end
                            else if (!in_range)
                            begin
                                rsp_next.status = ST_OUT_OF_RANGE;
                            end
                            else if (item_reg.action == ACT_WRITE)
                            begin
                                if (layout_reg == LAYOUT_DENSE || hit)
                                begin
                                    mem_wr_en = 1'b1;
                                end
                                else if (count_reg >= CNT_W'(LIST_DEPTH))
                                begin
                                    rsp_next.status = ST_LIST_FULL;
                                end
                                else
                                begin
                                    // A new key joins the list.
                                    mem_wr_en  = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            else if (hit)
                            begin
                                rsp_next.value_out = mem_rd_data[VALUE_W-1:0];
                            end
                            else if (layout_reg == LAYOUT_DENSE)
                            begin
                                rsp_next.value_out = NAN_WORD;
                            end
                            else
                            begin
                                rsp_next.status = ST_LIST_MISS;
                            end
                        end

                        default:
                        begin
                            // The unused action completes with no effect.
                        end
                    endcase

                    rsp_next.layout = layout_next;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            layout_reg    <= LAYOUT_UNSET;
            count_reg     <= '0;
            epoch_reg     <= EPOCH_W'(1);
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            layout_reg    <= layout_next;
            count_reg     <= count_next;
            epoch_reg     <= epoch_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sdss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sdss_checker
    import sdss_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_stall,
    input wire req_item_t            req,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_stall,
    input wire rsp_item_t            rsp
);

    // A held result stays in place until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("held result changed");

    // A stalled transaction stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("stalled transaction changed");

    // Only one transaction is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("transaction accepted while another is in flight");

    // Every failing transaction reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.value_out == '0)
        else $error("failed transaction returned data");

    // Before any prepare an access can only report not prepared.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.layout == LAYOUT_UNSET |->
            (rsp.status == ST_OK || rsp.status == ST_NOT_PREPARED))
        else $error("layout-dependent status with no layout");

endmodule

bind sparse_dense_surplus_store sdss_checker u_sdss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

FILE: bench/sparse_dense_surplus_store_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the sparse/dense surplus store.
//
// A short scripted sequence comes first. Its rows with an obvious answer carry
// that answer typed in, and the rest are checked against the behavioral
// predictor below. Random phases follow. Each phase programs a new set of
// layout registers while the store is idle, usually prepares, and then issues mostly
// well-formed writes and reads. Those accesses revisit keys already stored, so
// that list updates, hits and list-full cases are reached. A small share of
// out-of-range indexes, no-ops and mid-phase re-prepares is mixed in as noise.
// One phase issues a long run of prepares. That run carries the generation
// mark inside the store through a wrap, and reads after every prepare make
// sure that no stale written mark survives it.
module sparse_dense_surplus_store_tb;
    import sdss_pkg::*;

    // Action code 3 has no name in the package; the store treats it as a no-op.
    localparam logic [1:0] ACT_NOP = 2'd3;

    localparam int ITEM_GOAL    = 950;
    localparam int STORM_ROUNDS = 70;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_WAIT    = 20000;
    localparam int REPORT_CAP   = 100;

    typedef struct packed {
        logic                 is_cfg;
        logic [PTS_W-1:0]     pts;
        logic [PTS_W-1:0]     ex;
        logic [RATIO_W-1:0]   ratio;
        logic [THR_W-1:0]     thr;
        req_item_t            item;
        logic                 fixed;
        rsp_item_t            want;
    } step_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_item_t            req = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_item_t            rsp;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_POINTS;
    logic [CFG_W-1:0]     cfg_data = '0;

    sparse_dense_surplus_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the layout registers, as last programmed.
    logic [PTS_W-1:0]   cfg_points    = POINTS_RST;
    logic [PTS_W-1:0]   cfg_existing  = EXISTING_RST;
    logic [RATIO_W-1:0] cfg_ratio     = RATIO_RST;
    logic [THR_W-1:0]   cfg_threshold = THRESHOLD_RST;

    // Shadow of the store contents. The dense words are only ever read back
    // through their written marks, so their initial contents do not matter.
    logic [1:0]         layout_now = LAYOUT_UNSET;
    logic [VALUE_W-1:0] dense_word [SDSS_INDEX_SPACE];
    logic               dense_mark [SDSS_INDEX_SPACE];
    logic [INDEX_W-1:0] key_slot   [SDSS_LIST_DEPTH];
    logic [VALUE_W-1:0] word_slot  [SDSS_LIST_DEPTH];
    int                 slot_count = 0;

    // Results owed by the store, oldest first.
    rsp_item_t          owed_results[$];

    // Keys written since the last prepare; the random part re-uses them.
    logic [INDEX_W-1:0] written_keys[$];

    // Scripted sequence, walked in order.
    step_row_t          script[$];

    int  error_count  = 0;
    int  result_count = 0;
    int  list_picks   = 0;
    int  dense_picks  = 0;
    int  setting_sets = 0;
    int  status_tally [8];
    int  cycle_count  = 0;
    bit  calm         = 1'b0;

    initial
    begin
        foreach (dense_mark[i])
            dense_mark[i] = 1'b0;
        foreach (status_tally[i])
            status_tally[i] = 0;
    end

    function automatic void add_row(step_row_t s);
        script.insert(script.size(), s);
    endfunction

    // Computes what the store returns for one accepted transaction and
    // advances the shadow state the same way.
    function automatic rsp_item_t model_access(req_item_t a);
        rsp_item_t          o;
        int                 slot;
        int unsigned        span;
        logic [63:0]        occupancy;
        logic [63:0]        bound;
        o = '0;
        slot = -1;
        span = (cfg_points < 13'd4096) ? cfg_points : SDSS_INDEX_SPACE;
        for (int i = 0; i < slot_count; i++)
            if (key_slot[i] == a.flat_index)
                slot = i;
        // Occupancy against the Q16 bound, done by cross-multiplying.
        occupancy = 64'(cfg_existing) << 16;
        bound = 64'(cfg_ratio) * 64'(cfg_points);
        case (a.action)
            ACT_PREPARE:
            begin
                if (occupancy < bound && cfg_existing < 13'(cfg_threshold))
                begin
                    layout_now = LAYOUT_LIST;
                    list_picks++;
                end
                else
                begin
                    layout_now = LAYOUT_DENSE;
                    dense_picks++;
                end
                foreach (dense_mark[i])
                    dense_mark[i] = 1'b0;
                slot_count = 0;
            end
            ACT_WRITE, ACT_READ:
            begin
                if (layout_now == LAYOUT_UNSET)
                    o.status = ST_NOT_PREPARED;
                else if (a.flat_index >= span)
                    o.status = ST_OUT_OF_RANGE;
                else if (layout_now == LAYOUT_DENSE)
                begin
                    if (a.action == ACT_WRITE)
                    begin
                        dense_word[a.flat_index] = a.value_in;
                        dense_mark[a.flat_index] = 1'b1;
                    end
                    else
                        o.value_out = dense_mark[a.flat_index] ? dense_word[a.flat_index]
                                                               : NAN_WORD;
                end
                else if (a.action == ACT_WRITE)
                begin
                    if (slot >= 0)
                        word_slot[slot] = a.value_in;
                    else if (slot_count >= SDSS_LIST_DEPTH)
                        o.status = ST_LIST_FULL;
                    else
                    begin
                        key_slot[slot_count] = a.flat_index;
                        word_slot[slot_count] = a.value_in;
                        slot_count++;
                    end
                end
                else if (slot >= 0)
                    o.value_out = word_slot[slot];
                else
                    o.status = ST_LIST_MISS;
            end
            default:
                ;
        endcase
        o.layout = layout_now;
        return o;
    endfunction

    function automatic req_item_t make_access(logic [1:0] act, logic [INDEX_W-1:0] idx,
                                              logic [VALUE_W-1:0] v);
        req_item_t a;
        a.action = act;
        a.flat_index = idx;
        a.value_in = v;
        return a;
    endfunction

    function automatic step_row_t item_row(logic [1:0] act, logic [INDEX_W-1:0] idx,
                                           logic [VALUE_W-1:0] v);
        step_row_t s;
        s = '0;
        s.item = make_access(act, idx, v);
        return s;
    endfunction

    function automatic step_row_t known_row(logic [1:0] act, logic [INDEX_W-1:0] idx,
                                            logic [VALUE_W-1:0] v, logic [VALUE_W-1:0] vo,
                                            logic [2:0] st, logic [1:0] lay);
        step_row_t s;
        s = item_row(act, idx, v);
        s.fixed = 1'b1;
        s.want.value_out = vo;
        s.want.status = st;
        s.want.layout = lay;
        return s;
    endfunction

    function automatic step_row_t cfg_row(logic [PTS_W-1:0] pts, logic [PTS_W-1:0] ex,
                                          logic [RATIO_W-1:0] ratio, logic [THR_W-1:0] thr);
        step_row_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.pts = pts;
        s.ex = ex;
        s.ratio = ratio;
        s.thr = thr;
        return s;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    // During calm phases neither side idles at all.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        // Past the cap the count keeps running but the log stays short.
        if (error_count < REPORT_CAP)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Offers one transaction and returns at the edge that accepts it. It is
    // entered and left right after a rising edge, so valid gets at most one
    // assignment per edge. The stall line is sampled at the falling edge,
    // where nothing the bench drives is moving.
    task automatic send_access(input req_item_t it, input logic fixed, input rsp_item_t want);
        int        gap;
        rsp_item_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        @(negedge clk);
        while (req_stall)
            @(negedge clk);
        @(posedge clk);
        predicted = model_access(it);
        owed_results.insert(owed_results.size(), fixed ? want : predicted);
    endtask

    // Stops offering and waits until every owed result has been taken, so that no
    // transaction is in flight when the registers change.
    task automatic drain();
        req_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // All four registers go in one after another on consecutive edges, with the write
    // enable held high throughout.
    task automatic program_regs(input logic [PTS_W-1:0] pts, input logic [PTS_W-1:0] ex,
                                input logic [RATIO_W-1:0] ratio, input logic [THR_W-1:0] thr);
        cfg_we <= 1'b1;
        cfg_index <= REG_POINTS;
        cfg_data <= CFG_W'(pts);
        @(posedge clk);
        cfg_index <= REG_EXISTING;
        cfg_data <= CFG_W'(ex);
        @(posedge clk);
        cfg_index <= REG_RATIO;
        cfg_data <= CFG_W'(ratio);
        @(posedge clk);
        cfg_index <= REG_THRESHOLD;
        cfg_data <= CFG_W'(thr);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_points = pts;
        cfg_existing = ex;
        cfg_ratio = ratio;
        cfg_threshold = thr;
        setting_sets++;
    endtask

    task automatic check_result(input rsp_item_t got);
        rsp_item_t want;
        result_count++;
        status_tally[got.status]++;
        if (owed_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      result_count));
            return;
        end
        want = owed_results.pop_front();
        if (got.value_out !== want.value_out)
            report_mismatch($sformatf("result %0d value_out %h, predicted %h",
                                      result_count, got.value_out, want.value_out));
        if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                      result_count, got.status, want.status));
        if (got.layout !== want.layout)
            report_mismatch($sformatf("result %0d layout %0d, predicted %0d",
                                      result_count, got.layout, want.layout));
    endtask

    // Result side: the check looks at values held since the last rising edge,
    // and the stall for the next edge is driven at the rising edge.
    initial
    begin : result_side
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (rsp_valid && !rsp_stall)
                check_result(rsp);
            @(posedge clk);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                hold = hold - 1;
            end
            else
            begin
                hold = pick_gap();
                rsp_stall <= (hold > 0);
                if (hold > 0)
                    hold = hold - 1;
            end
        end
    end

    // A hung handshake ends the run here. The bound covers the clearing
    // passes after reset and after every wrap of the generation mark.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped by the cycle limit with %0d results outstanding.",
                     owed_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        step_row_t          row;
        logic [INDEX_W-1:0] idx;
        logic [INDEX_W-1:0] prev_key;
        logic [VALUE_W-1:0] word;
        logic [1:0]         act;
        logic [PTS_W-1:0]   pts;
        logic [PTS_W-1:0]   ex;
        logic [RATIO_W-1:0] ratio;
        logic [THR_W-1:0]   thr;
        int                 phase;
        int                 n;
        int                 r;
        int                 p_write;
        int                 p_fresh;
        int                 span;
        int                 random_items;
        int                 directed_items;
        int                 w;
        logic               fill;

        // Every access before the first prepare is refused, and a no-op
        // passes through untouched.
        add_row(known_row(ACT_READ, 12'd0, '0, '0, ST_NOT_PREPARED, LAYOUT_UNSET));
        add_row(known_row(ACT_WRITE, 12'd4095, '1, '0, ST_NOT_PREPARED, LAYOUT_UNSET));
        add_row(known_row(ACT_NOP, 12'd4095, '1, '0, ST_OK, LAYOUT_UNSET));
        // The reset settings describe an empty subspace, so the list is chosen.
        add_row(known_row(ACT_PREPARE, 12'd0, '0, '0, ST_OK, LAYOUT_LIST));
        add_row(item_row(ACT_WRITE, 12'd0, '0));
        add_row(item_row(ACT_WRITE, 12'd4095, '1));
        add_row(item_row(ACT_READ, 12'd4095, '0));
        add_row(known_row(ACT_READ, 12'd7, '0, '0, ST_LIST_MISS, LAYOUT_LIST));
        add_row(item_row(ACT_WRITE, 12'd0, 64'h8000_0000_0000_0001));
        add_row(item_row(ACT_READ, 12'd0, '0));
        // With no points at all the ratio test fails and the dense array is
        // empty, so every index is out of range.
        add_row(cfg_row(13'd0, 13'd0, 17'd0, 7'd0));
        add_row(known_row(ACT_PREPARE, 12'd0, '0, '0, ST_OK, LAYOUT_DENSE));
        add_row(known_row(ACT_WRITE, 12'd0, '1, '0, ST_OUT_OF_RANGE, LAYOUT_DENSE));
        add_row(known_row(ACT_READ, 12'd0, '0, '0, ST_OUT_OF_RANGE, LAYOUT_DENSE));
        // Every register at the top of its field: the point count is clipped
        // to the index space and the existing count rules out the list.
        add_row(cfg_row(13'd8191, 13'd8191, 17'd131071, 7'd127));
        add_row(known_row(ACT_PREPARE, 12'd0, '0, '0, ST_OK, LAYOUT_DENSE));
        add_row(known_row(ACT_READ, 12'd4095, '0, NAN_WORD, ST_OK, LAYOUT_DENSE));
        add_row(item_row(ACT_WRITE, 12'd4095, 64'h5555_AAAA_5555_AAAA));
        add_row(item_row(ACT_READ, 12'd4095, '0));
        add_row(known_row(ACT_READ, 12'd0, '0, NAN_WORD, ST_OK, LAYOUT_DENSE));
        add_row(known_row(ACT_NOP, 12'd0, '1, '0, ST_OK, LAYOUT_DENSE));
        // A second prepare forgets what was written before it.
        add_row(known_row(ACT_PREPARE, 12'd0, '0, '0, ST_OK, LAYOUT_DENSE));
        add_row(known_row(ACT_READ, 12'd4095, '0, NAN_WORD, ST_OK, LAYOUT_DENSE));
        // A single point, none present: list of one possible key.
        add_row(cfg_row(13'd1, 13'd0, 17'd1, 7'd1));
        add_row(known_row(ACT_PREPARE, 12'd0, '0, '0, ST_OK, LAYOUT_LIST));
        add_row(known_row(ACT_WRITE, 12'd1, '1, '0, ST_OUT_OF_RANGE, LAYOUT_LIST));
        add_row(item_row(ACT_WRITE, 12'd0, '1));
        add_row(item_row(ACT_READ, 12'd0, '0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        directed_items = 0;
        foreach (script[i])
        begin
            row = script[i];
            if (row.is_cfg)
            begin
                drain();
                program_regs(row.pts, row.ex, row.ratio, row.thr);
            end
            else
            begin
                send_access(row.item, row.fixed, row.want);
                directed_items++;
            end
        end

        phase = 0;
        random_items = 0;
        while (random_items < ITEM_GOAL)
        begin
            phase++;
            // Every fifth phase runs with both sides at full rate.
            calm = (phase % 5 == 0);
            r = $urandom_range(0, 99);
            if (phase == 1)
            begin
                // Upper ends of the documented ranges.
                pts = 13'd4096;
                ex = 13'd4096;
                ratio = 17'd65536;
                thr = 7'd64;
            end
            else if (phase == 2)
            begin
                // Small subspace for the prepare run, either layout.
                pts = 13'd16;
                ex = 13'($urandom_range(0, 16));
                ratio = 17'($urandom_range(0, 65536));
                thr = 7'($urandom_range(0, 64));
            end
            else if (r < 55)
            begin
                // Sparse subspace, chosen so that the list layout usually wins.
                ex = 13'($urandom_range(0, 40));
                pts = 13'($urandom_range(48, 4096));
                ratio = 17'($urandom_range(16384, 65536));
                thr = 7'($urandom_range(int'(ex) + 1, 127));
            end
            else if (r < 80)
            begin
                pts = 13'($urandom_range(1, 300));
                ex = 13'($urandom_range(0, 4096));
                ratio = 17'($urandom_range(0, 65536));
                thr = 7'($urandom_range(0, 64));
            end
            else
            begin
                // Whole field widths, beyond the documented ranges too.
                pts = 13'($urandom_range(0, 8191));
                ex = 13'($urandom_range(0, 8191));
                ratio = 17'($urandom_range(0, 131071));
                thr = 7'($urandom_range(0, 127));
            end
            drain();
            program_regs(pts, ex, ratio, thr);
            span = (cfg_points < 13'd4096) ? int'(cfg_points) : SDSS_INDEX_SPACE;

            if (phase == 2)
            begin
                // Long run of prepares. Each round reads the key written in
                // the round before, which must read as unwritten again.
                prev_key = '0;
                for (int k = 0; k < STORM_ROUNDS; k++)
                begin
                    send_access(make_access(ACT_PREPARE, '0, '0), 1'b0, '0);
                    send_access(make_access(ACT_READ, prev_key, '0), 1'b0, '0);
                    prev_key = 12'($urandom_range(0, 15));
                    word = {$urandom, $urandom};
                    send_access(make_access(ACT_WRITE, prev_key, word), 1'b0, '0);
                    random_items += 3;
                end
                continue;
            end

            // Fill phases add many new keys so that the list runs full.
            fill = ($urandom_range(0, 3) == 0);
            p_write = fill ? 85 : 55;
            p_fresh = fill ? 90 : 40;
            n = $urandom_range(15, 110);
            written_keys.delete();
            // Now and then the old contents are kept under the new settings.
            if ($urandom_range(0, 9) != 0)
            begin
                send_access(make_access(ACT_PREPARE, '0, '0), 1'b0, '0);
                random_items++;
            end
            for (int k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    act = ACT_NOP;
                else if (r < 5)
                    act = ACT_PREPARE;
                else if ($urandom_range(0, 99) < p_write)
                    act = ACT_WRITE;
                else
                    act = ACT_READ;

                if ($urandom_range(0, 99) < 7)
                    idx = 12'($urandom_range(0, 4095));
                else if (written_keys.size() > 0 && $urandom_range(0, 99) >= p_fresh)
                    idx = written_keys[$urandom_range(0, written_keys.size() - 1)];
                else if (span > 0)
                    idx = 12'($urandom_range(0, span - 1));
                else
                    idx = 12'($urandom_range(0, 4095));

                r = $urandom_range(0, 15);
                if (r == 0)
                    word = '0;
                else if (r == 1)
                    word = '1;
                else
                    word = {$urandom, $urandom};

                if (act == ACT_PREPARE)
                    written_keys.delete();
                else if (act == ACT_WRITE && written_keys.size() < 128)
                    written_keys.insert(written_keys.size(), idx);

                send_access(make_access(act, idx, word), 1'b0, '0);
                if (act != ACT_NOP)
                    random_items++;
            end
        end
        calm = 1'b0;

        // Wind down: stop offering, collect what is owed, then listen a
        // little longer for any result that should not exist.
        req_valid <= 1'b0;
        w = 0;
        while (w < TAIL_WAIT && owed_results.size() != 0)
        begin
            @(posedge clk);
            w++;
        end
        repeat (10) @(posedge clk);
        if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

        $display("Covered %0d transactions (%0d scripted) over %0d register settings;",
                 result_count, directed_items, setting_sets);
        $display("prepares chose list %0d and dense %0d times; ok %0d, miss %0d, %s %0d, %s",
                 list_picks, dense_picks, status_tally[ST_OK], status_tally[ST_LIST_MISS],
                 "unprepared", status_tally[ST_NOT_PREPARED],
                 $sformatf("full %0d, out of range %0d.", status_tally[ST_LIST_FULL],
                           status_tally[ST_OUT_OF_RANGE]));
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
